// ----- sv/seu_pkg.sv -----
// Shared types, widths and helpers for the SIR cell update unit.
// No dependencies; imported by every module of the block.
package seu_pkg;

    // Configuration of the datapath
    localparam int NEIGHBOURS = 8;
    localparam int FRAC_BITS  = 15;

    // Fixed field widths
    localparam int DATA_W    = 16;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Internal arithmetic widths
    localparam int PROD_W  = 2 * DATA_W;
    localparam int TERMS   = MASK_W + 1;
    localparam int GROUPS  = 3;
    localparam int GRP_W   = PROD_W + 2;
    localparam int X_W     = PROD_W + 4;
    localparam int SPLIT_W = X_W / 2;
    localparam int PART_W  = DATA_W + SPLIT_W;
    localparam int T3_W    = DATA_W + X_W;
    localparam int T3R_W   = (2 * FRAC_BITS + 1 > T3_W + 1) ? 2 * FRAC_BITS + 1 : T3_W + 1;
    localparam int T_W     = T3R_W - 2 * FRAC_BITS;
    localparam int D_W     = PROD_W + 1 - FRAC_BITS;
    localparam int MAG_A   = (T_W > D_W) ? T_W : D_W;
    localparam int MAG_W   = (MAG_A > DATA_W) ? MAG_A : DATA_W;
    localparam int RES_W   = MAG_W + 3;

    // Fixed-point one and saturation ceiling
    localparam int unsigned ONE_VAL = 32'd1 << FRAC_BITS;
    localparam int unsigned SAT_MAX = (ONE_VAL < 32'd65535) ? ONE_VAL : 32'd65535;

    typedef logic [DATA_W-1:0] t_data;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECOVERY  = 2'd0,
        CFG_INFECTION = 2'd1,
        CFG_WEIGHT    = 2'd2
    } t_cfg_index;

    // Rate registers handed to the sum pipeline
    typedef struct packed {
        t_data recovery;
        t_data infection;
        t_data weight;
    } t_rates;

    // One cell's own fractions
    typedef struct packed {
        t_data s;
        t_data i;
        t_data r;
    } t_cell;

    // Clamp a signed result to the range 0 .. SAT_MAX
    function automatic t_data sat_result(input logic signed [RES_W-1:0] x);
        logic signed [RES_W-1:0] lim;
        lim = $signed(RES_W'(SAT_MAX));
        if (x < 0) begin
            return '0;
        end else if (x > lim) begin
            return DATA_W'(SAT_MAX);
        end else begin
            return x[DATA_W-1:0];
        end
    endfunction

endpackage

// ----- sv/sir_epidemic_cell_update_unit.sv -----
// Each accepted request yields a one-cycle result strobe on o_valid.
// Throughput: one request per cycle; busy stays low, so start is taken every cycle.
// Six register stages: products, two adder-tree levels, split multiply, rounding, clamp.
// Reset (synchronous, active low) clears all valid bits and loads the rate registers.
// The receiver cannot stall; results leave on a fixed schedule.
module sir_epidemic_cell_update_unit
    import seu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0]     i_cfg_data,
    input  logic [DATA_W-1:0]     i_susceptible_in,
    input  logic [DATA_W-1:0]     i_infected_in,
    input  logic [DATA_W-1:0]     i_recovered_in,
    input  logic [MASK_W-1:0]     i_neighbour_mask,
    input  logic [DATA_W-1:0]     i_nb_infected_0,
    input  logic [DATA_W-1:0]     i_nb_infected_1,
    input  logic [DATA_W-1:0]     i_nb_infected_2,
    input  logic [DATA_W-1:0]     i_nb_infected_3,
    input  logic [DATA_W-1:0]     i_nb_infected_4,
    input  logic [DATA_W-1:0]     i_nb_infected_5,
    input  logic [DATA_W-1:0]     i_nb_infected_6,
    input  logic [DATA_W-1:0]     i_nb_infected_7,
    output logic                  o_valid,
    output logic [DATA_W-1:0]     o_susceptible_out,
    output logic [DATA_W-1:0]     o_infected_out,
    output logic [DATA_W-1:0]     o_recovered_out
);

    localparam logic [T3R_W-1:0] T_HALF = T3R_W'(1) << (2 * FRAC_BITS - 1);
    localparam int CELL_DLY = 3;

    t_rates                 r_rates;
    t_data [MASK_W-1:0]     w_nb;
    logic                   w_accept;
    t_cell                  w_cell;
    t_cell                  r_cell_dly [CELL_DLY];
    logic                   w_s3_valid;
    logic [X_W-1:0]         w_x;
    logic [D_W-1:0]         w_d;

    logic                   r_s4_valid, r_s5_valid, r_valid;
    logic [PART_W-1:0]      r_s4_plo, r_s4_phi;
    logic [D_W-1:0]         r_s4_d, r_s5_d;
    t_cell                  r_s4_cell, r_s5_cell;
    logic [T3R_W-1:0]       w_t3;
    logic [T_W-1:0]         r_s5_t;
    logic signed [RES_W-1:0] w_s_new, w_i_new, w_r_new;
    t_data                  r_s_out, r_i_out, r_r_out;

    // Never hold off a request
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_nb = {i_nb_infected_7, i_nb_infected_6, i_nb_infected_5, i_nb_infected_4,
                   i_nb_infected_3, i_nb_infected_2, i_nb_infected_1, i_nb_infected_0};
    assign w_cell = '{s: i_susceptible_in, i: i_infected_in, r: i_recovered_in};

    // Write the rate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rates.recovery  <= DATA_W'(13107);
            r_rates.infection <= DATA_W'(19661);
            r_rates.weight    <= DATA_W'(9830);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RECOVERY:  r_rates.recovery  <= i_cfg_data;
                CFG_INFECTION: r_rates.infection <= i_cfg_data;
                CFG_WEIGHT:    r_rates.weight    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Neighbour sum and recovered amount
    seu_sum_pipe u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_rates    (r_rates),
        .i_infected (i_infected_in),
        .i_mask     (i_neighbour_mask),
        .i_nb       (w_nb),
        .o_valid    (w_s3_valid),
        .o_x        (w_x),
        .o_d        (w_d)
    );

    // Hold the cell's own fractions alongside the sum pipeline
    always_ff @(posedge i_clk) begin
        r_cell_dly[0] <= w_cell;
        for (int k = 1; k < CELL_DLY; k++) begin
            r_cell_dly[k] <= r_cell_dly[k-1];
        end
    end

    // Rebuild the infection term and round it half up
    assign w_t3 = T3R_W'(r_s4_plo) + (T3R_W'(r_s4_phi) << SPLIT_W) + T_HALF;

    // Form the three new fractions
    assign w_s_new = $signed(RES_W'(r_s5_cell.s)) - $signed(RES_W'(r_s5_t));
    assign w_i_new = $signed(RES_W'(r_s5_cell.i)) - $signed(RES_W'(r_s5_d))
                   + $signed(RES_W'(r_s5_t));
    assign w_r_new = $signed(RES_W'(r_s5_cell.r)) + $signed(RES_W'(r_s5_d));

    // Advance valid bits of the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s4_valid <= w_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_valid    <= r_s5_valid;
        end
    end

    // Split multiply, rounding and clamping stages
    always_ff @(posedge i_clk) begin
        r_s4_plo  <= PART_W'(r_cell_dly[CELL_DLY-1].s) * PART_W'(w_x[SPLIT_W-1:0]);
        r_s4_phi  <= PART_W'(r_cell_dly[CELL_DLY-1].s) * PART_W'(w_x[X_W-1:SPLIT_W]);
        r_s4_d    <= w_d;
        r_s4_cell <= r_cell_dly[CELL_DLY-1];
        r_s5_t    <= T_W'(w_t3 >> (2 * FRAC_BITS));
        r_s5_d    <= r_s4_d;
        r_s5_cell <= r_s4_cell;
        r_s_out   <= sat_result(w_s_new);
        r_i_out   <= sat_result(w_i_new);
        r_r_out   <= sat_result(w_r_new);
    end

    assign o_valid           = r_valid;
    assign o_susceptible_out = r_s_out;
    assign o_infected_out    = r_i_out;
    assign o_recovered_out   = r_r_out;

endmodule

// ----- sv/seu_sum_pipe.sv -----
// Three-stage front end: neighbour products, adder tree and recovered amount.
// Depends on seu_pkg for widths and the rate struct.
module seu_sum_pipe
    import seu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_rates                   i_rates,
    input  t_data                    i_infected,
    input  logic [MASK_W-1:0]        i_mask,
    input  t_data [MASK_W-1:0]       i_nb,
    output logic                     o_valid,
    output logic [X_W-1:0]           o_x,
    output logic [D_W-1:0]           o_d
);

    localparam logic [PROD_W:0] D_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic                     r_s1_valid, r_s2_valid, r_s3_valid;
    logic [PROD_W-1:0]        r_prod [MASK_W];
    logic [PROD_W-1:0]        n_prod [MASK_W];
    logic [PROD_W-1:0]        r_vi, r_ei;
    logic [GRP_W-1:0]         r_grp [GROUPS];
    logic [GRP_W-1:0]         n_grp [GROUPS];
    logic [PROD_W-1:0]        w_term [TERMS];
    logic [PROD_W:0]          w_dsum;
    logic [D_W-1:0]           r_s2_d, r_s3_d;
    logic [X_W-1:0]           r_x;

    // Weight each present neighbour
    always_comb begin
        for (int k = 0; k < MASK_W; k++) begin
            if (k < NEIGHBOURS && i_mask[k]) begin
                n_prod[k] = PROD_W'(i_rates.weight) * PROD_W'(i_nb[k]);
            end else begin
                n_prod[k] = '0;
            end
        end
    end

    // Gather the terms into three partial sums
    always_comb begin
        for (int k = 0; k < MASK_W; k++) begin
            w_term[k] = r_prod[k];
        end
        w_term[MASK_W] = r_vi;
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g] = GRP_W'(w_term[3*g]) + GRP_W'(w_term[3*g+1]) + GRP_W'(w_term[3*g+2]);
        end
    end

    // Round the recovered amount half up
    assign w_dsum = {1'b0, r_ei} + D_HALF;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Advance payload through the three stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MASK_W; k++) begin
            r_prod[k] <= n_prod[k];
        end
        r_vi <= PROD_W'(i_rates.infection) * PROD_W'(i_infected);
        r_ei <= PROD_W'(i_rates.recovery) * PROD_W'(i_infected);
        for (int g = 0; g < GROUPS; g++) begin
            r_grp[g] <= n_grp[g];
        end
        r_s2_d <= D_W'(w_dsum >> FRAC_BITS);
        r_x    <= X_W'(r_grp[0]) + X_W'(r_grp[1]) + X_W'(r_grp[2]);
        r_s3_d <= r_s2_d;
    end

    assign o_valid = r_s3_valid;
    assign o_x     = r_x;
    assign o_d     = r_s3_d;

endmodule

// ----- sv/seu_checker.sv -----
// Port-level checks for the SIR cell update unit, bound to the top level.
// Depends on seu_pkg for widths and the saturation ceiling.
module seu_checker
    import seu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [DATA_W-1:0]     i_susceptible_in,
    input  logic [DATA_W-1:0]     i_infected_in,
    input  logic [DATA_W-1:0]     i_recovered_in,
    input  logic [MASK_W-1:0]     i_neighbour_mask,
    input  logic                  o_valid,
    input  logic [DATA_W-1:0]     o_susceptible_out,
    input  logic [DATA_W-1:0]     o_infected_out,
    input  logic [DATA_W-1:0]     o_recovered_out
);

    localparam logic [DATA_W-1:0] SAT_V = DATA_W'(SAT_MAX);
    localparam logic [2:0] PIPE_DEPTH = 3'd6;

    logic [2:0] r_live;
    logic       w_clean6;

    // Count cycles out of reset, up to the pipeline depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (r_live != PIPE_DEPTH) begin
            r_live <= r_live + 3'd1;
        end
    end

    assign w_clean6 = (r_live == PIPE_DEPTH);

    // Each accepted request yields a result strobe, and no strobe appears without one
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clean6 |-> (o_valid == $past(start && !busy, 6)))
        else $error("result strobe does not match request six cycles earlier");

    // No result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe raised after reset");

    // Results stay within the saturation range
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_susceptible_out <= SAT_V && o_infected_out <= SAT_V
                     && o_recovered_out <= SAT_V))
        else $error("result above the saturation ceiling");

    // A cell with no infection and no neighbours passes through unchanged
    a_no_infection: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_clean6 && o_valid && $past(i_neighbour_mask == '0, 6)
         && $past(i_infected_in == '0, 6)
         && $past(i_susceptible_in <= SAT_V, 6) && $past(i_recovered_in <= SAT_V, 6))
        |-> (o_infected_out == '0 && o_susceptible_out == $past(i_susceptible_in, 6)
             && o_recovered_out == $past(i_recovered_in, 6)))
        else $error("idle cell changed its fractions");

    // Requests are never refused
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind sir_epidemic_cell_update_unit seu_checker u_seu_checker (.*);
